### src/xts_pkg.sv
`default_nettype none
package xts_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DATA_KEY_LOW   = 3'd0,
        REG_DATA_KEY_HIGH  = 3'd1,
        REG_TWEAK_KEY_LOW  = 3'd2,
        REG_TWEAK_KEY_HIGH = 3'd3,
        REG_DIRECTION      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic         new_sector;
        logic [127:0] tweak;
        logic [127:0] block;
    } item_t;

    function automatic logic [7:0] xt(input logic [7:0] b);
        xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a_in, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] a;
        p = 8'h00;
        a = a_in;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = xt(a);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r = 8'h01;
        base = x;
        e = 8'd254;
        for (int i = 0; i < 8; i++)
        begin
            if (e[i])
                r = gmul(r, base);
            base = gmul(base, base);
        end
        ginv = (x == 8'h00) ? 8'h00 : r;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] v;
        v = ginv(x);
        sbox = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
               ^ {v[3:0], v[7:4]} ^ 8'h63;
    endfunction

    // Affine inverse followed by field inverse
    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] y;
        y = {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05;
        inv_sbox = ginv(y);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 1; i < 10; i++)
        begin
            if (4'(i) < rnd)
                r = xt(r);
        end
        rcon = r;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [3:0] rnd);
        logic [31:0] t;
        logic [127:0] w;
        t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
             sbox(k[111:104]) ^ rcon(rnd)};
        w[31:0]   = k[31:0] ^ t;
        w[63:32]  = k[63:32] ^ w[31:0];
        w[95:64]  = k[95:64] ^ w[63:32];
        w[127:96] = k[127:96] ^ w[95:64];
        next_round_key = w;
    endfunction

    // Inverse of next_round_key: rebuild key rnd-1 from key rnd
    function automatic logic [127:0] prev_round_key(input logic [127:0] w,
                                                    input logic [3:0] rnd);
        logic [127:0] k;
        logic [31:0] t;
        k[127:96] = w[127:96] ^ w[95:64];
        k[95:64]  = w[95:64] ^ w[63:32];
        k[63:32]  = w[63:32] ^ w[31:0];
        t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
             sbox(k[111:104]) ^ rcon(rnd)};
        k[31:0] = w[31:0] ^ t;
        prev_round_key = k;
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            b[i] = sbox(s[8*i +: 8]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r + 4*c] = b[r + 4*((c + r) % 4)];
        for (int c = 0; c < 4; c++)
        begin
            if (last)
            begin
                for (int r = 0; r < 4; r++)
                    o[8*(4*c+r) +: 8] = t[4*c+r];
            end
            else
            begin
                o[8*(4*c)   +: 8] = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                o[8*(4*c+1) +: 8] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
                o[8*(4*c+2) +: 8] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3];
                o[8*(4*c+3) +: 8] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3]);
            end
        end
        enc_round = o;
    endfunction

    // Inverse shift and substitute, add key, then inverse mix unless last
    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] t [16];
        logic [7:0] a [16];
        logic [127:0] o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r + 4*((c + r) % 4)] = s[8*(r + 4*c) +: 8];
        for (int i = 0; i < 16; i++)
            a[i] = inv_sbox(t[i]) ^ rk[8*i +: 8];
        for (int c = 0; c < 4; c++)
        begin
            if (last)
            begin
                for (int r = 0; r < 4; r++)
                    o[8*(4*c+r) +: 8] = a[4*c+r];
            end
            else
            begin
                o[8*(4*c)   +: 8] = gmul(a[4*c], 8'd14) ^ gmul(a[4*c+1], 8'd11)
                                  ^ gmul(a[4*c+2], 8'd13) ^ gmul(a[4*c+3], 8'd9);
                o[8*(4*c+1) +: 8] = gmul(a[4*c], 8'd9) ^ gmul(a[4*c+1], 8'd14)
                                  ^ gmul(a[4*c+2], 8'd11) ^ gmul(a[4*c+3], 8'd13);
                o[8*(4*c+2) +: 8] = gmul(a[4*c], 8'd13) ^ gmul(a[4*c+1], 8'd9)
                                  ^ gmul(a[4*c+2], 8'd14) ^ gmul(a[4*c+3], 8'd11);
                o[8*(4*c+3) +: 8] = gmul(a[4*c], 8'd11) ^ gmul(a[4*c+1], 8'd13)
                                  ^ gmul(a[4*c+2], 8'd9) ^ gmul(a[4*c+3], 8'd14);
            end
        end
        dec_round = o;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] t);
        gf_double = {t[126:0], 1'b0} ^ {120'd0, (t[127] ? 8'h87 : 8'h00)};
    endfunction

endpackage
`default_nettype wire

### src/xts_front.sv
`default_nettype none
// Input queue between the port and the cipher engine
module xts_front #(
    parameter int DEPTH = 2
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  wire xts_pkg::item_t in_item,
    output logic                item_valid,
    output xts_pkg::item_t      item,
    input  wire                 item_take
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    xts_pkg::item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          wr, rd;

    assign full = (count_reg == (AW+1)'(DEPTH));
    assign item_valid = (count_reg != '0);
    assign item = mem[rd_ptr_reg];
    assign wr = push && !full;
    assign rd = item_take && item_valid;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

### src/xts_engine.sv
`default_nettype none
// One AES round a cycle; tweak pass first on a sector start, then the data pass
module xts_engine (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    input  wire xts_pkg::item_t item,
    output logic                item_take,
    input  wire [127:0]         data_key,
    input  wire [127:0]         tweak_key,
    input  wire                 direction,
    output logic                empty,
    input  wire                 pop,
    output logic [127:0]        result
);
    typedef enum logic [1:0] {S_IDLE, S_TWEAK, S_DATA, S_DONE} state_t;

    state_t        state_reg;
    logic [3:0]    rnd_reg;
    logic [127:0]  s_reg, rk_reg, tw_reg, blk_reg, res_reg;
    logic          dk_last_reg;
    logic          res_valid_reg;
    logic          dir_reg;
    logic          out_free;

    assign out_free  = !res_valid_reg || pop;
    assign item_take = (state_reg == S_IDLE) && item_valid;
    assign empty  = !res_valid_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rnd_reg       <= '0;
            tw_reg        <= '0;
            res_valid_reg <= 1'b0;
            dir_reg       <= 1'b0;
            s_reg         <= '0;
            rk_reg        <= '0;
            blk_reg       <= '0;
            dk_last_reg   <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    // last data round key is needed first when decrypting
                    if (item_valid)
                    begin
                        blk_reg <= item.block;
                        dir_reg <= direction;
                        rnd_reg <= 4'd0;
                        if (item.new_sector)
                        begin
                            s_reg   <= item.tweak ^ tweak_key;
                            rk_reg  <= tweak_key;
                            state_reg <= S_TWEAK;
                        end
                        else
                        begin
                            s_reg   <= item.block ^ tw_reg ^ (direction ? 128'd0 : data_key);
                            rk_reg  <= data_key;
                            state_reg <= S_DATA;
                        end
                    end
                end
                S_TWEAK:
                begin
                    begin
                        logic [127:0] nk, ns;
                        nk = xts_pkg::next_round_key(rk_reg, rnd_reg + 4'd1);
                        ns = xts_pkg::enc_round(s_reg, rnd_reg == 4'd9) ^ nk;
                        rk_reg <= nk;
                        if (rnd_reg == 4'd9)
                        begin
                            tw_reg  <= ns;
                            s_reg   <= blk_reg ^ ns ^ (dir_reg ? 128'd0 : data_key);
                            rk_reg  <= data_key;
                            rnd_reg <= 4'd0;
                            state_reg <= S_DATA;
                        end
                        else
                        begin
                            s_reg   <= ns;
                            rnd_reg <= rnd_reg + 4'd1;
                        end
                    end
                end
                S_DATA:
                begin
                    // encrypt: rounds 1..10; decrypt: expand key to round ten, then 10 rounds
                    begin
                        logic [127:0] nk, pk, ns;
                        nk = xts_pkg::next_round_key(rk_reg, rnd_reg + 4'd1);
                        if (!dir_reg)
                        begin
                            ns = xts_pkg::enc_round(s_reg, rnd_reg == 4'd9) ^ nk;
                            rk_reg <= nk;
                            if (rnd_reg == 4'd9)
                            begin
                                s_reg <= ns ^ tw_reg;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                s_reg <= ns;
                                rnd_reg <= rnd_reg + 4'd1;
                            end
                        end
                        else if (!dk_last_reg && rnd_reg != 4'd15)
                        begin
                            // forward pass to reach round key ten
                            rk_reg <= nk;
                            if (rnd_reg == 4'd9)
                            begin
                                s_reg   <= s_reg ^ nk;
                                rnd_reg <= 4'd15;
                            end
                            else
                                rnd_reg <= rnd_reg + 4'd1;
                        end
                        else
                        begin
                            // rnd_reg 15 marks the start of the inverse rounds
                            logic [3:0] r;
                            r = (rnd_reg == 4'd15) ? 4'd0 : rnd_reg;
                            pk = xts_pkg::prev_round_key(rk_reg, 4'd10 - r);
                            ns = xts_pkg::dec_round(s_reg, pk, r == 4'd9);
                            rk_reg <= pk;
                            if (r == 4'd9)
                            begin
                                s_reg <= ns ^ tw_reg;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                s_reg <= ns;
                                rnd_reg <= r + 4'd1;
                                dk_last_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_DONE:
                begin
                    // hold the finished block until the result register is free
                    if (out_free)
                    begin
                        res_reg <= s_reg;
                        res_valid_reg <= 1'b1;
                        tw_reg <= xts_pkg::gf_double(tw_reg);
                        dk_last_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/xts_aes128_sector_cipher_top.sv
`default_nettype none
// A data block runs a data pass of ten rounds; a sector start adds a tweak pass
// of ten rounds first, and decrypt adds a key-schedule pass before its rounds.
// A new block is taken only once the previous one has reached the result register.
// A two-entry input queue and one result register decouple both sides.
// Reset (rst_n low, asynchronous) clears keys, direction, running tweak and queues.
module xts_aes128_sector_cipher_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire         new_sector,
    input  wire [63:0]  tweak_low,
    input  wire [63:0]  tweak_high,
    input  wire [63:0]  block_low,
    input  wire [63:0]  block_high,
    output logic        empty,
    input  wire         pop,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    input  wire         cfg_we,
    input  wire [xts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [63:0]  cfg_data
);
    logic [63:0] dkl_reg, dkh_reg, tkl_reg, tkh_reg;
    logic        dir_reg;
    xts_pkg::item_t in_item, item;
    logic        item_valid, item_take;
    logic [127:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dkl_reg <= '0;
            dkh_reg <= '0;
            tkl_reg <= '0;
            tkh_reg <= '0;
            dir_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                xts_pkg::REG_DATA_KEY_LOW:   dkl_reg <= cfg_data;
                xts_pkg::REG_DATA_KEY_HIGH:  dkh_reg <= cfg_data;
                xts_pkg::REG_TWEAK_KEY_LOW:  tkl_reg <= cfg_data;
                xts_pkg::REG_TWEAK_KEY_HIGH: tkh_reg <= cfg_data;
                xts_pkg::REG_DIRECTION:      dir_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item.new_sector = new_sector;
    assign in_item.tweak = {tweak_high, tweak_low};
    assign in_item.block = {block_high, block_low};

    xts_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .item_valid(item_valid), .item(item), .item_take(item_take)
    );

    xts_engine u_engine (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item(item),
        .item_take(item_take), .data_key({dkh_reg, dkl_reg}),
        .tweak_key({tkh_reg, tkl_reg}), .direction(dir_reg),
        .empty(empty), .pop(pop), .result(result)
    );

    assign result_low  = result[63:0];
    assign result_high = result[127:64];
endmodule
`default_nettype wire

### src/xts_checker.sv
`default_nettype none
module xts_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        push,
    input wire        full,
    input wire        empty,
    input wire        pop,
    input wire [63:0] result_low,
    input wire [63:0] result_high
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_low) && $stable(result_high)))
        else $error("result changed while waiting");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("handshake output unknown");
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("queue filled without a transfer");
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result waiting right after reset");
endmodule

bind xts_aes128_sector_cipher_top xts_checker u_xts_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
    .result_low(result_low), .result_high(result_high)
);
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [xts_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_BLOCKS = 1950;
    localparam int PHASES = 8;

    typedef struct {
        logic         new_sector;
        logic [127:0] tweak;
        logic [127:0] block;
        logic         typed;
        logic [127:0] result;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        new_sector = 1'b0;
    logic [63:0] tweak_low = '0;
    logic [63:0] tweak_high = '0;
    logic [63:0] block_low = '0;
    logic [63:0] block_high = '0;
    logic        pop = 1'b0;
    logic        cfg_we = 1'b0;
    logic [xts_pkg::CFG_IDX_W-1:0] cfg_index = xts_pkg::REG_DATA_KEY_LOW;
    logic [63:0] cfg_data = '0;
    wire         full;
    wire         empty;
    wire [63:0]  result_low;
    wire [63:0]  result_high;

    xts_aes128_sector_cipher_top u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .new_sector(new_sector), .tweak_low(tweak_low), .tweak_high(tweak_high),
        .block_low(block_low), .block_high(block_high),
        .empty(empty), .pop(pop), .result_low(result_low), .result_high(result_high),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [7:0]   sub_tab [256];
    logic [7:0]   inv_sub_tab [256];
    logic [127:0] data_key;
    logic [127:0] tweak_key;
    logic         decrypt_mode;
    logic [127:0] sector_tweak;

    logic [127:0] cipher_q [$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = xtime(a);
        end
        return p;
    endfunction

    function automatic void build_sub_tables();
        logic [7:0] v;
        for (int x = 0; x < 256; x++)
        begin
            v = 8'h00;
            for (int y = 1; y < 256; y++)
                if (x != 0 && fmul(8'(x), 8'(y)) == 8'h01)
                    v = 8'(y);
            sub_tab[x] = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                         ^ {v[3:0], v[7:4]} ^ 8'h63;
        end
        for (int x = 0; x < 256; x++)
            inv_sub_tab[sub_tab[x]] = 8'(x);
    endfunction

    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [7:0] t [4];
        logic [127:0] n;
        t[0] = sub_tab[k[8*13 +: 8]] ^ rc;
        t[1] = sub_tab[k[8*14 +: 8]];
        t[2] = sub_tab[k[8*15 +: 8]];
        t[3] = sub_tab[k[8*12 +: 8]];
        for (int j = 0; j < 4; j++)
            n[8*j +: 8] = k[8*j +: 8] ^ t[j];
        for (int j = 4; j < 16; j++)
            n[8*j +: 8] = k[8*j +: 8] ^ n[8*(j-4) +: 8];
        return n;
    endfunction

    function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] blk,
                                            input logic inverse);
        logic [127:0] rk [11];
        logic [7:0] rc;
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        rc = 8'h01;
        rk[0] = key;
        for (int r = 1; r <= 10; r++)
        begin
            rk[r] = next_key(rk[r-1], rc);
            rc = xtime(rc);
        end
        if (!inverse)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = blk[8*i +: 8] ^ rk[0][8*i +: 8];
            for (int rnd = 1; rnd <= 10; rnd++)
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        t[r + 4*c] = sub_tab[s[r + 4*((c + r) % 4)]];
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    if (rnd == 10)
                    begin
                        s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                    end
                    else
                    begin
                        s[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                        s[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                        s[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                        s[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
                    end
                end
                for (int i = 0; i < 16; i++)
                    s[i] = s[i] ^ rk[rnd][8*i +: 8];
            end
        end
        else
        begin
            for (int i = 0; i < 16; i++)
                s[i] = blk[8*i +: 8] ^ rk[10][8*i +: 8];
            for (int rnd = 9; rnd >= 0; rnd--)
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        t[r + 4*((c + r) % 4)] = s[r + 4*c];
                for (int i = 0; i < 16; i++)
                    s[i] = inv_sub_tab[t[i]] ^ rk[rnd][8*i +: 8];
                if (rnd != 0)
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        s[4*c]   = fmul(a0, 8'd14) ^ fmul(a1, 8'd11) ^ fmul(a2, 8'd13)
                                   ^ fmul(a3, 8'd9);
                        s[4*c+1] = fmul(a0, 8'd9) ^ fmul(a1, 8'd14) ^ fmul(a2, 8'd11)
                                   ^ fmul(a3, 8'd13);
                        s[4*c+2] = fmul(a0, 8'd13) ^ fmul(a1, 8'd9) ^ fmul(a2, 8'd14)
                                   ^ fmul(a3, 8'd11);
                        s[4*c+3] = fmul(a0, 8'd11) ^ fmul(a1, 8'd13) ^ fmul(a2, 8'd9)
                                   ^ fmul(a3, 8'd14);
                    end
            end
        end
        for (int i = 0; i < 16; i++)
            o[8*i +: 8] = s[i];
        return o;
    endfunction

    // Compute one XTS block and advance the sector tweak
    function automatic logic [127:0] xts_block(input logic ns, input logic [127:0] tw_in,
                                               input logic [127:0] blk);
        logic [127:0] tw;
        logic [127:0] r;
        if (ns)
            sector_tweak = aes128(tweak_key, tw_in, 1'b0);
        tw = sector_tweak;
        r = aes128(data_key, blk ^ tw, decrypt_mode) ^ tw;
        sector_tweak = {tw[126:0], 1'b0} ^ (tw[127] ? 128'h87 : 128'h0);
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input logic ns, input logic [127:0] tw, input logic [127:0] blk,
                              input logic typed, input logic [127:0] typed_result);
        logic [127:0] r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        new_sector <= ns;
        {tweak_high, tweak_low} <= tw;
        {block_high, block_low} <= blk;
        do
            @(posedge clk);
        while (full);
        r = xts_block(ns, tw, blk);
        if (typed && r !== typed_result)
        begin
            $display("%0t: table entry disagrees with predictor: %h vs %h",
                     $realtime, typed_result, r);
            errors++;
        end
        cipher_q.push_back(typed ? typed_result : r);
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [xts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            xts_pkg::REG_DATA_KEY_LOW:   data_key[63:0] = value;
            xts_pkg::REG_DATA_KEY_HIGH:  data_key[127:64] = value;
            xts_pkg::REG_TWEAK_KEY_LOW:  tweak_key[63:0] = value;
            xts_pkg::REG_TWEAK_KEY_HIGH: tweak_key[127:64] = value;
            xts_pkg::REG_DIRECTION:      decrypt_mode = value[0];
            default: ;
        endcase
    endtask

    // receiver side: random pop, check each transfer against the oldest prediction
    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && pop && !empty)
        begin
            if (cipher_q.size() == 0)
            begin
                $display("%0t: unexpected result %h_%h", $realtime, result_high, result_low);
                errors++;
            end
            else
            begin
                if (result_low !== cipher_q[0][63:0])
                begin
                    $display("%0t: result_low expected %h actual %h",
                             $realtime, cipher_q[0][63:0], result_low);
                    errors++;
                end
                if (result_high !== cipher_q[0][127:64])
                begin
                    $display("%0t: result_high expected %h actual %h",
                             $realtime, cipher_q[0][127:64], result_high);
                    errors++;
                end
                void'(cipher_q.pop_front());
            end
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        logic [127:0] ones;
        logic [63:0] kv;
        ones = '1;
        data_key = '0;
        tweak_key = '0;
        decrypt_mode = 1'b0;
        sector_tweak = '0;
        build_sub_tables();

        // zero key on a zero block with no sector start: plain AES of zero
        rows.push_back('{1'b0, '0, '0, 1'b1, {64'h2e2b34ca59fa4c88, 64'h3b2c8aefd44be966}});
        rows.push_back('{1'b0, ones, ones, 1'b0, '0});
        rows.push_back('{1'b1, ones, ones, 1'b0, '0});
        rows.push_back('{1'b0, '0, '0, 1'b0, '0});
        rows.push_back('{1'b0, ones, 128'h1, 1'b0, '0});
        rows.push_back('{1'b1, '0, '0, 1'b0, '0});
        rows.push_back('{1'b1, {64'h8000000000000000, 64'h0}, ones, 1'b0, '0});
        for (int i = 0; i < 12; i++)
            rows.push_back('{1'b0, {rand_word(), rand_word()}, {rand_word(), rand_word()},
                             1'b0, '0});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_block(rows[i].new_sector, rows[i].tweak, rows[i].block,
                       rows[i].typed, rows[i].result);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            for (int r = 0; r < 4; r++)
            begin
                kv = (ph == 0) ? '1 : (ph == 1) ? '0 : {$urandom, $urandom};
                write_reg(xts_pkg::cfg_idx_t'(r), kv);
            end
            // upper bits of the direction write must be ignored
            write_reg(xts_pkg::REG_DIRECTION, {{63{ph[1]}}, ph[0]});
            write_reg(REG_UNUSED, {$urandom, $urandom});
            @(negedge clk);
            cfg_we <= 1'b0;
            case (ph / 2)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 69; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 69; end
                default: begin send_idle_pct = 24; pop_stall_pct = 24; end
            endcase
            for (int n = 0; n < RANDOM_BLOCKS / PHASES; n++)
                send_block($urandom_range(7) == 0, {rand_word(), rand_word()},
                           {rand_word(), rand_word()}, 1'b0, '0);
        end

        drain();
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire

### xts_aes128_sector_cipher_top.f
src/xts_pkg.sv
src/xts_front.sv
src/xts_engine.sv
src/xts_aes128_sector_cipher_top.sv
src/xts_checker.sv
sim/testbench.sv
